// ===== sv/arm_pkg.sv =====
// ----------------------------------------------------------------------------
// arm_pkg: shared types and constants
// Item and result structs, the queue entry between front and back, the
// register map and the sequencer states of the reach-and-minimize block.
// ----------------------------------------------------------------------------
package arm_pkg;

	localparam int MAX_STATES_DEF   = 64;
	localparam int MAX_TOKENS_DEF   = 8;
	localparam int WEIGHT_WIDTH_DEF = 16;
	localparam int RESULT_LIMIT     = 64;

	// register indexes on the configuration port
	localparam logic [1:0] REG_STATE_COUNT   = 2'd0;
	localparam logic [1:0] REG_TOKEN_COUNT   = 2'd1;
	localparam logic [1:0] REG_INITIAL_STATE = 2'd2;

	typedef struct packed {
		logic [5:0]  state_index;
		logic [2:0]  token_index;
		logic [15:0] emission_weight;
		logic [5:0]  successor_state;
		logic        last_entry;
	} item_t;

	typedef struct packed {
		logic [5:0] result_state;
		logic [5:0] class_id;
		logic [6:0] class_count;
		logic       is_reachable;
		logic       table_error;
		logic       last_state;
	} result_t;

	typedef struct packed {
		logic [6:0] state_count;
		logic [3:0] token_count;
		logic [5:0] initial_state;
	} cfg_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		logic  store;
		item_t item;
	} job_t;

	// back end status toward the front end
	typedef struct packed {
		logic pop;
		logic done;
	} back_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,
		ST_ERR_END,
		ST_WALK_INIT,
		ST_WALK_POP,
		ST_WALK_CUR,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_REF_START,
		ST_Q_START,
		ST_C_RD,
		ST_C_GET,
		ST_A_RD,
		ST_A_CLS,
		ST_A_CMP,
		ST_NEW_CLS,
		ST_REF_END,
		ST_OUT_RD,
		ST_OUT_EM,
		ST_FINISH
	} back_state_t;

endpackage

// ===== sv/automaton_reach_and_minimize.sv =====
// ----------------------------------------------------------------------------
// automaton_reach_and_minimize: reachability and Moore class refinement
// Loads a weighted automaton entry by entry, then reports reachability and
// the coarsest stable class of every state.
// ----------------------------------------------------------------------------
// Usage:
//   Set state_count, token_count and initial_state over the APB port while
//   the block is idle. Load table entries with start while busy is low; one
//   entry is taken per cycle. The entry with last_entry set starts the
//   computation and busy stays high until its results are out.
//   After the last entry the block checks every successor, walks the states
//   reached from initial_state token by token, then runs rounds of
//   refinement until the class count stays the same; then it gives n
//   results, each marked by result_valid for a single cycle.
//   The receiver cannot stall; results are never held.
//   Reset clears marks, counters and registers; table memories keep
//   undefined contents until loaded, class memories until written.
// ----------------------------------------------------------------------------
module automaton_reach_and_minimize import arm_pkg::*; #(
	parameter int MAX_STATES   = MAX_STATES_DEF,
	parameter int MAX_TOKENS   = MAX_TOKENS_DEF,
	parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        result_valid,
	output result_t     result
);

	cfg_t       cfg_q;
	job_t       head;
	back_stat_t stat;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_count   <= 7'd1;
			cfg_q.token_count   <= 4'd1;
			cfg_q.initial_state <= 6'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_STATE_COUNT:   cfg_q.state_count   <= pwdata[6:0];
				REG_TOKEN_COUNT:   cfg_q.token_count   <= pwdata[3:0];
				REG_INITIAL_STATE: cfg_q.initial_state <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			REG_STATE_COUNT:   prdata = {25'd0, cfg_q.state_count};
			REG_TOKEN_COUNT:   prdata = {28'd0, cfg_q.token_count};
			REG_INITIAL_STATE: prdata = {26'd0, cfg_q.initial_state};
			default:           prdata = 32'd0;
		endcase
	end

	arm_front #(
		.MAX_STATES (MAX_STATES),
		.MAX_TOKENS (MAX_TOKENS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.busy   (busy),
		.head   (head)
	);

	arm_back #(
		.MAX_STATES   (MAX_STATES),
		.MAX_TOKENS   (MAX_TOKENS),
		.WEIGHT_WIDTH (WEIGHT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.cfg          (cfg_q),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== sv/arm_front.sv =====
// ----------------------------------------------------------------------------
// arm_front: item intake
// Accepts load items, flags entries that fall inside the table and queues
// them for the back end. Holds off new items while a computation runs or the queue is full.
// ----------------------------------------------------------------------------
module arm_front import arm_pkg::*; #(
	parameter int MAX_STATES = MAX_STATES_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  item_t      item,
	input  back_stat_t stat,
	output logic       busy,
	output job_t       head
);

	job_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pend_q;
	logic       accept;
	job_t       job_in;

	// classify the incoming entry
	always_comb begin
		accept       = start && !busy;
		job_in.valid = 1'b1;
		job_in.store = (int'(item.state_index) < MAX_STATES) &&
		               (int'(item.token_index) < MAX_TOKENS);
		job_in.item  = item;
	end

	// present the queue head
	always_comb begin
		head       = fifo_q[rd_q];
		head.valid = (cnt_q != 2'd0);
	end

	assign busy = pend_q || (cnt_q == 2'd2);

	// store entries
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_q] <= job_in;
		end
	end

	// advance pointers and track a pending computation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= 2'd0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				wr_q <= !wr_q;
			end
			if (stat.pop) begin
				rd_q <= !rd_q;
			end
			case ({accept, stat.pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
			if (accept && item.last_entry) begin
				pend_q <= 1'b1;
			end else if (stat.done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/arm_back.sv =====
// ----------------------------------------------------------------------------
// arm_back: table store and sequencer
// Writes queued entries into the weight and successor memories. On the last
// entry it checks successors, walks reachable states and refines classes,
// then emits one result per state.
// ----------------------------------------------------------------------------
module arm_back import arm_pkg::*; #(
	parameter int MAX_STATES   = MAX_STATES_DEF,
	parameter int MAX_TOKENS   = MAX_TOKENS_DEF,
	parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  cfg_t       cfg,
	output back_stat_t stat,
	output logic       result_valid,
	output result_t    result
);

	localparam int LIM   = (MAX_STATES < RESULT_LIMIT) ? MAX_STATES : RESULT_LIMIT;
	localparam int SW    = $clog2(LIM);
	localparam int NW    = $clog2(LIM + 1);
	localparam int KW    = $clog2(MAX_TOKENS + 1);
	localparam int DEPTH = LIM * MAX_TOKENS;
	localparam int AW    = $clog2(DEPTH);

	back_state_t state_q, state_d;

	// memories
	logic [WEIGHT_WIDTH-1:0] wmem [DEPTH];
	logic [5:0]              smem [DEPTH];
	logic [SW-1:0]           cls0 [LIM];
	logic [SW-1:0]           cls1 [LIM];
	logic [SW-1:0]           rep_mem [LIM];
	logic [SW-1:0]           wq_mem [LIM];

	// read data
	logic [WEIGHT_WIDTH-1:0] wa_q, wb_q;
	logic [5:0]              sa_q, sb_q;
	logic [SW-1:0]           cp0_q, cp1_q, cq0_q, cq1_q;
	logic [SW-1:0]           rep_rd_q, wq_rd_q;

	// control and counters
	logic [NW-1:0]  n_q, found_q, prev_q, head_q, tail_q;
	logic [KW-1:0]  t_q, a_q;
	logic [5:0]     init_q;
	logic [SW-1:0]  q_q, c_q, rep_q, cur_q;
	logic           bank_q, first_q, err_q, chk_q;
	logic           weq_q, inp_q, inq_q;
	logic [LIM-1:0] reach_q;

	// combinational controls
	logic [AW-1:0] addr_a, addr_b;
	logic [SW-1:0] cla, clb;
	logic [NW-1:0] n_new;
	logic [KW-1:0] t_new;
	logic [6:0]    n7;
	logic          last_a, last_q, last_c, match, walk_new;
	logic [SW-1:0] cls_p, cls_q;
	logic          cls_we, rep_we;
	logic [SW-1:0] cls_wdata;

	function automatic logic [AW-1:0] taddr(input logic [SW-1:0] r, input logic [KW-1:0] k);
		return AW'(r) * AW'(MAX_TOKENS) + AW'(k);
	endfunction

	// clamp the counts at the start of a computation
	always_comb begin
		if (cfg.state_count == 7'd0) begin
			n_new = NW'(1);
		end else if (int'(cfg.state_count) > LIM) begin
			n_new = NW'(LIM);
		end else begin
			n_new = NW'(cfg.state_count);
		end
		if (cfg.token_count == 4'd0) begin
			t_new = KW'(1);
		end else if (int'(cfg.token_count) > MAX_TOKENS) begin
			t_new = KW'(MAX_TOKENS);
		end else begin
			t_new = KW'(cfg.token_count);
		end
	end

	// loop ends and signature compare
	always_comb begin
		n7       = 7'(n_q);
		last_a   = (a_q + KW'(1)) == t_q;
		last_q   = (NW'(q_q) + NW'(1)) == n_q;
		last_c   = (NW'(c_q) + NW'(1)) == found_q;
		cls_p    = bank_q ? cp1_q : cp0_q;
		cls_q    = bank_q ? cq1_q : cq0_q;
		match    = weq_q && (inp_q == inq_q) && (!inp_q || first_q || (cls_p == cls_q));
		walk_new = (wa_q != '0) && ({1'b0, sa_q} < n7) && !reach_q[SW'(sa_q)];
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		stat.pop  = 1'b0;
		stat.done = 1'b0;
		addr_a    = taddr(q_q, a_q);
		addr_b    = taddr(q_q, a_q);
		cla       = SW'(sa_q);
		clb       = (state_q == ST_OUT_RD) ? q_q : SW'(sb_q);
		cls_we    = 1'b0;
		cls_wdata = c_q;
		rep_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				stat.pop = head.valid;
				if (head.valid && head.item.last_entry) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR: begin
				if (last_a && last_q) begin
					state_d = ST_ERR_END;
				end
			end
			ST_ERR_END:   state_d = ST_WALK_INIT;
			ST_WALK_INIT: state_d = ST_WALK_POP;
			ST_WALK_POP:  state_d = (head_q == tail_q) ? ST_REF_START : ST_WALK_CUR;
			ST_WALK_CUR:  state_d = ST_WALK_RD;
			ST_WALK_RD: begin
				addr_a  = taddr(cur_q, a_q);
				state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK:  state_d = last_a ? ST_WALK_POP : ST_WALK_RD;
			ST_REF_START: state_d = ST_Q_START;
			ST_Q_START:   state_d = (found_q == '0) ? ST_NEW_CLS : ST_C_RD;
			ST_C_RD:      state_d = ST_C_GET;
			ST_C_GET:     state_d = ST_A_RD;
			ST_A_RD: begin
				addr_a  = taddr(rep_q, a_q);
				state_d = ST_A_CLS;
			end
			ST_A_CLS:     state_d = ST_A_CMP;
			ST_A_CMP: begin
				if (match && last_a) begin
					cls_we  = 1'b1;
					state_d = last_q ? ST_REF_END : ST_Q_START;
				end else if (match) begin
					state_d = ST_A_RD;
				end else begin
					state_d = last_c ? ST_NEW_CLS : ST_C_RD;
				end
			end
			ST_NEW_CLS: begin
				cls_we    = 1'b1;
				cls_wdata = SW'(found_q);
				rep_we    = 1'b1;
				state_d   = last_q ? ST_REF_END : ST_Q_START;
			end
			ST_REF_END:   state_d = (found_q == prev_q) ? ST_OUT_RD : ST_REF_START;
			ST_OUT_RD:    state_d = ST_OUT_EM;
			ST_OUT_EM:    state_d = last_q ? ST_FINISH : ST_OUT_RD;
			ST_FINISH: begin
				stat.done = 1'b1;
				state_d   = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table memories: write queued entries, read two rows
	always_ff @(posedge clk) begin
		if (stat.pop && head.store) begin
			wmem[taddr(SW'(head.item.state_index), KW'(head.item.token_index))] <=
				WEIGHT_WIDTH'(head.item.emission_weight);
			smem[taddr(SW'(head.item.state_index), KW'(head.item.token_index))] <=
				head.item.successor_state;
		end
		wa_q <= wmem[addr_a];
		sa_q <= smem[addr_a];
		wb_q <= wmem[addr_b];
		sb_q <= smem[addr_b];
	end

	// class memories: write the new bank, read two successors
	always_ff @(posedge clk) begin
		if (cls_we && bank_q) begin
			cls0[q_q] <= cls_wdata;
		end
		if (cls_we && !bank_q) begin
			cls1[q_q] <= cls_wdata;
		end
		cp0_q <= cls0[cla];
		cp1_q <= cls1[cla];
		cq0_q <= cls0[clb];
		cq1_q <= cls1[clb];
	end

	// representatives and walk queue
	always_ff @(posedge clk) begin
		if (rep_we) begin
			rep_mem[SW'(found_q)] <= q_q;
		end
		rep_rd_q <= rep_mem[c_q];
		if (state_q == ST_WALK_INIT) begin
			wq_mem[SW'(0)] <= SW'(init_q);
		end else if (state_q == ST_WALK_CHK && walk_new) begin
			wq_mem[SW'(tail_q)] <= SW'(sa_q);
		end
		wq_rd_q <= wq_mem[SW'(head_q)];
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= NW'(1);
			t_q          <= KW'(1);
			init_q       <= '0;
			q_q          <= '0;
			a_q          <= '0;
			c_q          <= '0;
			rep_q        <= '0;
			cur_q        <= '0;
			found_q      <= '0;
			prev_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			bank_q       <= 1'b0;
			first_q      <= 1'b1;
			err_q        <= 1'b0;
			chk_q        <= 1'b0;
			weq_q        <= 1'b0;
			inp_q        <= 1'b0;
			inq_q        <= 1'b0;
			reach_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			chk_q        <= (state_q == ST_ERR);
			result_valid <= 1'b0;
			if (chk_q && ({1'b0, sa_q} >= n7)) begin
				err_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid && head.item.last_entry) begin
						n_q     <= n_new;
						t_q     <= t_new;
						init_q  <= cfg.initial_state;
						q_q     <= '0;
						a_q     <= '0;
						err_q   <= 1'b0;
						first_q <= 1'b1;
						prev_q  <= NW'(1);
						found_q <= '0;
						head_q  <= '0;
						tail_q  <= '0;
					end
				end
				ST_ERR: begin
					if (last_a) begin
						a_q <= '0;
						q_q <= q_q + SW'(1);
					end else begin
						a_q <= a_q + KW'(1);
					end
				end
				ST_WALK_INIT: begin
					head_q <= '0;
					if ({1'b0, init_q} < n7) begin
						reach_q[SW'(init_q)] <= 1'b1;
						tail_q               <= NW'(1);
					end else begin
						tail_q <= '0;
					end
				end
				ST_WALK_POP: begin
					if (head_q != tail_q) begin
						head_q <= head_q + NW'(1);
					end
				end
				ST_WALK_CUR: begin
					cur_q <= wq_rd_q;
					a_q   <= '0;
				end
				ST_WALK_CHK: begin
					if (walk_new) begin
						reach_q[SW'(sa_q)] <= 1'b1;
						tail_q             <= tail_q + NW'(1);
					end
					a_q <= a_q + KW'(1);
				end
				ST_REF_START: begin
					q_q     <= '0;
					found_q <= '0;
				end
				ST_Q_START: begin
					c_q <= '0;
					a_q <= '0;
				end
				ST_C_GET: begin
					rep_q <= rep_rd_q;
					a_q   <= '0;
				end
				ST_A_CLS: begin
					weq_q <= (wa_q == wb_q);
					inp_q <= ({1'b0, sa_q} < n7);
					inq_q <= ({1'b0, sb_q} < n7);
				end
				ST_A_CMP: begin
					if (match && last_a) begin
						q_q <= q_q + SW'(1);
					end else if (match) begin
						a_q <= a_q + KW'(1);
					end else begin
						c_q <= c_q + SW'(1);
					end
				end
				ST_NEW_CLS: begin
					found_q <= found_q + NW'(1);
					q_q     <= q_q + SW'(1);
				end
				ST_REF_END: begin
					bank_q  <= !bank_q;
					first_q <= 1'b0;
					prev_q  <= found_q;
					q_q     <= '0;
				end
				// emit a result and drop the mark of that state
				ST_OUT_EM: begin
					result_valid   <= 1'b1;
					reach_q[q_q]   <= 1'b0;
					q_q            <= q_q + SW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_EM) begin
			result.result_state <= 6'(q_q);
			result.class_id     <= 6'(cls_q);
			result.class_count  <= 7'(found_q);
			result.is_reachable <= reach_q[q_q];
			result.table_error  <= err_q;
			result.last_state   <= last_q;
		end
	end

`ifndef ASSERT_OFF
	a_found_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= n_q) else $error("class count exceeds state count");
	a_tail_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= n_q) else $error("walk queue overrun");
	a_last_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_state |-> state_q == ST_FINISH)
		else $error("final result not followed by finish");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> !result_valid) else $error("result after finish");
`endif

endmodule
